@@ hw/rtl/fxalu_pkg.sv @@
// shared types and operation codes for the q24.8 fixed-point alu
`default_nettype none
package fxalu_pkg;
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_LT  = 4'd5;
  localparam logic [3:0] OP_GE  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;
  localparam logic [3:0] OP_NE  = 4'd9;
  localparam logic [3:0] OP_INC = 4'd10;
  localparam logic [3:0] OP_DEC = 4'd11;
  localparam logic [3:0] OP_MIN = 4'd12;
  localparam logic [3:0] OP_MAX = 4'd13;
  localparam logic [3:0] OP_FRI = 4'd14;
  localparam logic [3:0] OP_TOI = 4'd15;

  typedef struct packed {
    logic [3:0]   operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fxalu_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic compare_true;
    logic overflow;
    logic divide_by_zero;
  } fxalu_out_t;

  // per-item control carried along the cell chain
  typedef struct packed {
    logic        vld;
    logic [3:0]  op;
    logic        neg;
    logic        dz;
    logic signed [31:0] res;
    logic        cmp;
    logic        ovf;
  } fxalu_ctl_t;
endpackage
`default_nettype wire

@@ hw/rtl/fxalu_cell.sv @@
// one restoring-division step cell: shifts in one numerator bit per cycle while en is high
`default_nettype none
module fxalu_cell #(
  parameter int NW = 40
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire fxalu_pkg::fxalu_ctl_t ctl_in,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [NW:0]   rem_in,
  input  wire logic [31:0]   den_in,
  output fxalu_pkg::fxalu_ctl_t ctl_out,
  output logic [NW-1:0] num_out,
  output logic [NW:0]   rem_out,
  output logic [31:0]   den_out
);
  import fxalu_pkg::*;
  logic [NW:0] sh;
  logic [NW:0] diff;
  logic        ge;
  always_comb begin
    sh   = {rem_in[NW-1:0], num_in[NW-1]};
    diff = sh - {{(NW-31){1'b0}}, den_in};
    ge   = sh >= {{(NW-31){1'b0}}, den_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl_in;
      den_out <= den_in;
      rem_out <= ge ? diff : sh;
      num_out <= {num_in[NW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/fixed_point_q24_8_alu.sv @@
// fixed-point alu top level: front stage, division cell chain, output stage
// channels: in (valid/ready, fxalu_in_t) and out (valid/ready, fxalu_out_t)
// one transfer per cycle in each direction, sustained while out_ready is held high;
// every item takes the same path, through a chain of 32+FRACTION_BITS
// division cells, one quotient bit per cell, plus front and rounding stages
// non-division operations ride the same chain so results stay in order
// the whole chain advances only when the output register is empty or taken,
// so a receiver stall freezes the pipeline and backs up to in_ready
// the multiplier runs in the front stage with a register after it
// reset clears all valid bits; no item is lost or repeated on stalls
`default_nettype none
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire fxalu_pkg::fxalu_in_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output fxalu_pkg::fxalu_out_t out_data
);
  import fxalu_pkg::*;
  localparam int NW = 32 + FRACTION_BITS;
  localparam int NC = NW;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en && !rst;

  // front stage
  logic signed [32:0] a_ext, b_ext;
  logic [31:0] ma, mb;
  logic signed [33:0] sum, dif, inc, dec;
  logic signed [63:0] fri;
  fxalu_ctl_t ctl0;
  logic [63:0] prod;
  logic [NW-1:0] num0;
  logic [31:0] den0;

  function automatic logic [32:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat = {1'b1, 32'h7fffffff};
    else if (v < -64'sd2147483648) sat = {1'b1, 32'h80000000};
    else sat = {1'b0, v[31:0]};
  endfunction

  logic [32:0] s;
  always_comb begin
    a_ext = in_data.operand_a;
    b_ext = in_data.operand_b;
    ma = in_data.operand_a[31] ? 32'(-a_ext) : in_data.operand_a;
    mb = in_data.operand_b[31] ? 32'(-b_ext) : in_data.operand_b;
    sum = 34'(a_ext) + 34'(b_ext);
    dif = 34'(a_ext) - 34'(b_ext);
    inc = 34'(a_ext) + 34'sd1;
    dec = 34'(a_ext) - 34'sd1;
    fri = 64'(in_data.operand_a) <<< FRACTION_BITS;
    ctl0 = '0;
    ctl0.vld = in_valid;
    ctl0.op  = in_data.operation;
    ctl0.neg = in_data.operand_a[31] ^ in_data.operand_b[31];
    s = '0;
    case (in_data.operation)
      OP_ADD: s = sat(64'(sum));
      OP_SUB: s = sat(64'(dif));
      OP_INC: s = sat(64'(inc));
      OP_DEC: s = sat(64'(dec));
      OP_FRI: s = sat(fri);
      OP_MIN: s = {1'b0, (in_data.operand_a < in_data.operand_b) ?
                   in_data.operand_a : in_data.operand_b};
      OP_MAX: s = {1'b0, (in_data.operand_a > in_data.operand_b) ?
                   in_data.operand_a : in_data.operand_b};
      OP_TOI: s = {1'b0, 32'(in_data.operand_a >>> FRACTION_BITS)};
      default: s = '0;
    endcase
    ctl0.res = s[31:0];
    ctl0.ovf = s[32];
    case (in_data.operation)
      OP_GT: ctl0.cmp = in_data.operand_a >  in_data.operand_b;
      OP_LT: ctl0.cmp = in_data.operand_a <  in_data.operand_b;
      OP_GE: ctl0.cmp = in_data.operand_a >= in_data.operand_b;
      OP_LE: ctl0.cmp = in_data.operand_a <= in_data.operand_b;
      OP_EQ: ctl0.cmp = in_data.operand_a == in_data.operand_b;
      OP_NE: ctl0.cmp = in_data.operand_a != in_data.operand_b;
      default: ctl0.cmp = 1'b0;
    endcase
    ctl0.dz = (in_data.operation == OP_DIV) && (mb == '0);
    num0 = {ma, {FRACTION_BITS{1'b0}}};
    den0 = mb;
  end

  // stage 1 registers (product registered here)
  fxalu_ctl_t ctl1;
  logic [NW-1:0] num1;
  logic [31:0] den1;
  always_ff @(posedge clk) begin
    if (rst) ctl1.vld <= 1'b0;
    else if (en) ctl1.vld <= ctl0.vld && in_ready;
    if (en) begin
      {ctl1.op, ctl1.neg, ctl1.dz, ctl1.res, ctl1.cmp, ctl1.ovf} <=
        {ctl0.op, ctl0.neg, ctl0.dz, ctl0.res, ctl0.cmp, ctl0.ovf};
      num1 <= num0;
      den1 <= den0;
      prod <= 64'(ma) * 64'(mb);
    end
  end

  // multiply rounding; product travels in the chain through res fields
  logic [63:0] pq;
  logic [32:0] ms;
  fxalu_ctl_t ctl1m;
  always_comb begin
    pq = (prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    ms = '0;
    if (ctl1.neg) begin
      if (pq > 64'h80000000) ms = {1'b1, 32'h80000000};
      else ms = {1'b0, 32'(-pq)};
    end else begin
      if (pq > 64'h7fffffff) ms = {1'b1, 32'h7fffffff};
      else ms = {1'b0, pq[31:0]};
    end
    ctl1m = ctl1;
    if (ctl1.op == OP_MUL) begin
      ctl1m.res = ms[31:0];
      ctl1m.ovf = ms[32];
    end
  end

  // division cell chain
  fxalu_ctl_t    c_ctl [NC+1];
  logic [NW-1:0] c_num [NC+1];
  logic [NW:0]   c_rem [NC+1];
  logic [31:0]   c_den [NC+1];
  logic          c_vld [NC+1];
  assign c_ctl[0] = ctl1m;
  assign c_num[0] = num1;
  assign c_rem[0] = '0;
  assign c_den[0] = den1;
  assign c_vld[0] = ctl1.vld;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fxalu_ctl_t ct;
    fxalu_cell #(.NW(NW)) u_cell (
      .clk(clk), .en(en), .ctl_in(c_ctl[i]), .num_in(c_num[i]),
      .rem_in(c_rem[i]), .den_in(c_den[i]), .ctl_out(ct),
      .num_out(c_num[i+1]), .rem_out(c_rem[i+1]), .den_out(c_den[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) c_vld[i+1] <= 1'b0;
      else if (en) c_vld[i+1] <= c_vld[i];
    end
    always_comb begin
      c_ctl[i+1] = ct;
      c_ctl[i+1].vld = c_vld[i+1];
    end
  end

  // division rounding and output register
  fxalu_ctl_t ce;
  logic [NW-1:0] q;
  logic [NW:0] r;
  logic [NW:0] q1;
  logic [32:0] dsat;
  logic [33:0] r2;
  always_comb begin
    ce = c_ctl[NC];
    q  = c_num[NC];
    r  = c_rem[NC];
    r2 = {r[32:0], 1'b0};
    q1 = {1'b0, q} + ((r2 >= {2'b0, c_den[NC]}) ? (NW+1)'(1) : (NW+1)'(0));
    dsat = '0;
    if (ce.neg) begin
      if (q1 > (NW+1)'(33'h080000000)) dsat = {1'b1, 32'h80000000};
      else dsat = {1'b0, 32'(-q1)};
    end else begin
      if (q1 > (NW+1)'(32'h7fffffff)) dsat = {1'b1, 32'h7fffffff};
      else dsat = {1'b0, q1[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= c_vld[NC];
    if (en) begin
      out_data.compare_true <= ce.cmp;
      if (ce.op == OP_DIV) begin
        out_data.divide_by_zero <= ce.dz;
        out_data.result_value   <= ce.dz ? '0 : dsat[31:0];
        out_data.overflow       <= ce.dz ? 1'b0 : dsat[32];
      end else begin
        out_data.divide_by_zero <= 1'b0;
        out_data.result_value   <= ce.res;
        out_data.overflow       <= ce.ovf;
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/fxalu_checker.sv @@
// checker for the fixed-point alu: predicts each result and compares transfers
module fxalu_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  fxalu_pkg::fxalu_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  fxalu_pkg::fxalu_out_t out_data,
  output int                    fail_count,
  output int                    pending
);
  import fxalu_pkg::*;

  localparam int FB = 8;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  fxalu_out_t expected_q[$];

  function automatic fxalu_out_t alu_predict(fxalu_in_t x);
    fxalu_out_t o;
    longint a, b, r;
    longint unsigned ma, mb, p, q, rem;
    logic neg;
    a = x.operand_a;
    b = x.operand_b;
    r = 0;
    o = '0;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    q = 0;
    case (x.operation)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (FB - 1))) >> FB;
      end
      OP_DIV: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          p = ma << FB;
          q = p / mb;
          rem = p % mb;
          if (rem * 2 >= mb) q = q + 1;
        end
      end
      OP_GT: o.compare_true = a > b;
      OP_LT: o.compare_true = a < b;
      OP_GE: o.compare_true = a >= b;
      OP_LE: o.compare_true = a <= b;
      OP_EQ: o.compare_true = a == b;
      OP_NE: o.compare_true = a != b;
      OP_INC: r = a + 1;
      OP_DEC: r = a - 1;
      OP_MIN: r = a < b ? a : b;
      OP_MAX: r = a > b ? a : b;
      OP_FRI: r = a * (64'sd1 <<< FB);
      default: r = a >>> FB;
    endcase
    if ((x.operation == OP_MUL) || (x.operation == OP_DIV && b != 0)) begin
      if (neg) begin
        if (q > 64'h8000_0000) begin
          o.overflow = 1'b1;
          r = MINV;
        end else begin
          r = -longint'(q);
        end
      end else if (q > 64'h7FFF_FFFF) begin
        o.overflow = 1'b1;
        r = MAXV;
      end else begin
        r = q;
      end
    end else if (r > MAXV) begin
      o.overflow = 1'b1;
      r = MAXV;
    end else if (r < MINV) begin
      o.overflow = 1'b1;
      r = MINV;
    end
    o.result_value = r[31:0];
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    fxalu_out_t e;
    int nf;
    nf = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(alu_predict(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer %h", out_data);
          nf = nf + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.result_value !== out_data.result_value) begin
            $error("result_value exp %h got %h", e.result_value, out_data.result_value);
            nf = nf + 1;
          end
          if (e.compare_true !== out_data.compare_true) begin
            $error("compare_true exp %b got %b", e.compare_true, out_data.compare_true);
            nf = nf + 1;
          end
          if (e.overflow !== out_data.overflow) begin
            $error("overflow exp %b got %b", e.overflow, out_data.overflow);
            nf = nf + 1;
          end
          if (e.divide_by_zero !== out_data.divide_by_zero) begin
            $error("divide_by_zero exp %b got %b", e.divide_by_zero,
                   out_data.divide_by_zero);
            nf = nf + 1;
          end
        end
      end
      fail_count <= fail_count + nf;
    end
  end
endmodule

@@ tb/tb.sv @@
// testbench top for the fixed-point alu: stimulus, stalls and verdict
module tb;
  import fxalu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  fxalu_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fxalu_out_t out_data;
  int fail_count;
  int pending;
  longint cycles = 0;
  logic stim_done = 1'b0;

  fixed_point_q24_8_alu uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  fxalu_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall pattern: phases of always ready, random, mostly stalled
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_phase <= $urandom_range(0, 2);
      case (stall_phase)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 4095) - 2048;
      4: return 32'(int'($urandom_range(0, 65535)) - 32768) << 8;
      5: return $urandom & 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [3:0] op, input logic [31:0] a,
                           input logic [31:0] b);
    fxalu_in_t x;
    x.operation = op;
    x.operand_a = a;
    x.operand_b = b;
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  int burst;
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int op = 0; op < 16; op++) begin
      send_item(op[3:0], 32'h7FFF_FFFF, 32'h8000_0000);
    end
    send_item(OP_DIV, 32'h0000_0100, 32'h0);
    send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_DIV, 32'h0000_0001, 32'h0000_0002);
    send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
    send_item(OP_INC, 32'h7FFF_FFFF, 32'h0);
    send_item(OP_DEC, 32'h8000_0000, 32'h0);
    send_item(OP_FRI, 32'hFF80_0000, 32'h0);
    send_item(OP_TOI, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_MIN, 32'h0000_1234, 32'h0000_1234);
    idle_gap(1);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 1650; i += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
      if (i > 800 && i < 850) begin
        idle_gap(1);
        while (pending != 0) @(posedge clk);
      end else begin
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    @(posedge stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/fxalu_pkg.sv
hw/rtl/fxalu_cell.sv
hw/rtl/fixed_point_q24_8_alu.sv
tb/fxalu_checker.sv
tb/tb.sv
